@@ rtl/core/sfrm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfrm_pkg;

    localparam int TS_W     = 48;
    localparam int LEN_W    = 24;
    localparam int WIN_W    = 16;
    localparam int KIND_W   = 2;
    localparam int CNT_O_W  = 7;
    localparam int BITS_O_W = 33;
    localparam int MEAN_W   = 16;
    localparam int STEP_W   = $clog2(TS_W);

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd1000;

    typedef struct packed {
        logic add;
        logic clear;
        logic start;
        logic fetch;
        logic eval;
        logic span;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic occ_zero;
        logic walk_stop;
        logic div_last;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/core/sfrm_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfrm_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sfrm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfrm_ctrl
    import sfrm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [KIND_W-1:0] i_kind,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire t_sts              i_sts,
    output t_cmd                   o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FETCH = 6'b000010,
        S_WALK  = 6'b000100,
        S_SPAN  = 6'b001000,
        S_DIV   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_in_ready  = (r_state == S_IDLE);
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_kind)
                        KIND_ADD: begin
                            o_cmd.add = 1'b1;
                        end
                        KIND_CLEAR: begin
                            o_cmd.clear = 1'b1;
                        end
                        KIND_QUERY: begin
                            o_cmd.start = 1'b1;
                            n_state     = i_sts.occ_zero ? S_SPAN : S_FETCH;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.fetch = 1'b1;
                o_cmd.eval  = 1'b1;
                if (i_sts.walk_stop) begin
                    n_state = S_SPAN;
                end
            end
            S_SPAN: begin
                o_cmd.span = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

@@ rtl/core/sfrm_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfrm_dp
    import sfrm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [WIN_W-1:0]    i_cfg_wdata,
    input  wire logic [TS_W-1:0]     i_time_ms,
    input  wire logic [LEN_W-1:0]    i_frame_len,
    input  wire t_cmd                i_cmd,
    output t_sts                     o_sts,
    output logic [CNT_O_W-1:0]       o_window_frames,
    output logic [BITS_O_W-1:0]      o_window_bits,
    output logic [TS_W-1:0]          o_lifetime_frames,
    output logic [MEAN_W-1:0]        o_mean_interval_ms
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int BW    = LEN_W + CW;
    localparam int REC_W = LEN_W + TS_W;

    logic [WIN_W-1:0]  r_window;
    logic [AW-1:0]     r_slot;
    logic [CW-1:0]     r_occ;
    logic [TS_W-1:0]   r_total;
    logic [TS_W-1:0]   r_now;
    logic [AW-1:0]     r_ptr;
    logic [CW-1:0]     r_left;
    logic [CW-1:0]     r_count;
    logic [BW-1:0]     r_bytes;
    logic [TS_W-1:0]   r_newest;
    logic [TS_W-1:0]   r_oldest;
    logic [CW-1:0]     r_rem;
    logic [TS_W-1:0]   r_quo;
    logic [STEP_W-1:0] r_step;

    logic [REC_W-1:0]  rd_rec;
    logic [TS_W-1:0]   rd_time;
    logic [LEN_W-1:0]  rd_len;
    logic              age_ok;
    logic [TS_W-1:0]   span;
    logic [CW-1:0]     divisor;
    logic [CW:0]       trial;
    logic              q_bit;
    logic [BW+2:0]     bits_full;
    logic [63:0]       bits_w;
    logic [63:0]       cnt_w;

    sfrm_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add),
        .i_waddr (r_slot),
        .i_wdata ({i_frame_len, i_time_ms}),
        .i_re    (i_cmd.fetch),
        .i_raddr (r_ptr),
        .o_rdata (rd_rec)
    );

    assign rd_time = rd_rec[TS_W-1:0];
    assign rd_len  = rd_rec[REC_W-1:TS_W];
    assign age_ok  = (rd_time > r_now) || ((r_now - rd_time) <= TS_W'(r_window));
    assign span    = (r_oldest > r_newest) ? '0 : (r_newest - r_oldest);
    assign divisor = r_count - CW'(1);
    assign trial   = {r_rem, r_quo[TS_W-1]};
    assign q_bit   = (trial >= {1'b0, divisor});

    assign o_sts.occ_zero  = (r_occ == '0);
    assign o_sts.walk_stop = !age_ok || (r_left == CW'(1));
    assign o_sts.div_last  = (r_step == STEP_W'(TS_W - 1));

    assign bits_full = {r_bytes, 3'b000};
    assign bits_w    = 64'(bits_full);
    assign cnt_w     = 64'(r_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_slot   <= '0;
            r_occ    <= '0;
            r_total  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (i_cmd.add) begin
                r_slot  <= (r_slot == AW'(DEPTH - 1)) ? '0 : r_slot + AW'(1);
                r_total <= r_total + TS_W'(1);
                if (r_occ != CW'(DEPTH)) begin
                    r_occ <= r_occ + CW'(1);
                end
            end else if (i_cmd.clear) begin
                r_occ <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_now    <= i_time_ms;
            r_ptr    <= (r_slot == '0) ? AW'(DEPTH - 1) : r_slot - AW'(1);
            r_left   <= r_occ;
            r_count  <= '0;
            r_bytes  <= '0;
            r_newest <= '0;
            r_oldest <= '0;
        end else begin
            if (i_cmd.fetch) begin
                r_ptr <= (r_ptr == '0) ? AW'(DEPTH - 1) : r_ptr - AW'(1);
            end
            if (i_cmd.eval && age_ok) begin
                r_count  <= r_count + CW'(1);
                r_bytes  <= r_bytes + BW'(rd_len);
                r_oldest <= rd_time;
                r_left   <= r_left - CW'(1);
                if (r_count == '0) begin
                    r_newest <= rd_time;
                end
            end
        end
        if (i_cmd.span) begin
            r_quo  <= span;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= q_bit ? CW'(trial - {1'b0, divisor}) : trial[CW-1:0];
            r_quo  <= {r_quo[TS_W-2:0], q_bit};
            r_step <= r_step + STEP_W'(1);
        end
        if (i_cmd.load_out) begin
            o_window_frames    <= (cnt_w > 64'd127) ? 7'd127 : cnt_w[CNT_O_W-1:0];
            o_window_bits      <= (bits_w > 64'h1_FFFF_FFFF) ? '1 : bits_w[BITS_O_W-1:0];
            o_lifetime_frames  <= r_total;
            if (r_count < CW'(2)) begin
                o_mean_interval_ms <= '0;
            end else if (r_quo > TS_W'(16'hFFFF)) begin
                o_mean_interval_ms <= '1;
            end else begin
                o_mean_interval_ms <= r_quo[MEAN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/sliding_window_frame_rate_meter.sv @@
// Channel   Valid          Ready          Payload
// request   i_in_valid     o_in_ready     i_kind, i_time_ms, i_frame_len
// result    o_out_valid    i_out_ready    o_window_frames, o_window_bits,
//                                         o_lifetime_frames, o_mean_interval_ms
// config    i_cfg_we       (none)         i_cfg_wdata
//
// Add, clear and unused kinds are handled in the idle state without leaving it.
// A query on a nonempty ring passes FETCH, WALK, SPAN, DIV and OUT, reading 1 to DEPTH records:
// one record read per cycle from the record RAM, then a 48-step serial divide.
// A query on an empty ring skips the reads and goes straight to SPAN.
// A query result waits in the output register; add and clear requests are still
// taken meanwhile, and a later query stalls at its end until the register frees.
// Reset is synchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_frame_rate_meter
    import sfrm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [WIN_W-1:0]    i_cfg_wdata,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [KIND_W-1:0]   i_kind,
    input  wire logic [TS_W-1:0]     i_time_ms,
    input  wire logic [LEN_W-1:0]    i_frame_len,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [CNT_O_W-1:0]       o_window_frames,
    output logic [BITS_O_W-1:0]      o_window_bits,
    output logic [TS_W-1:0]          o_lifetime_frames,
    output logic [MEAN_W-1:0]        o_mean_interval_ms
);

    t_cmd cmd;
    t_sts sts;

    sfrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    sfrm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_time_ms          (i_time_ms),
        .i_frame_len        (i_frame_len),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_window_frames    (o_window_frames),
        .o_window_bits      (o_window_bits),
        .o_lifetime_frames  (o_lifetime_frames),
        .o_mean_interval_ms (o_mean_interval_ms)
    );

endmodule

`default_nettype wire

@@ rtl/core/sfrm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfrm_checker
    import sfrm_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic [KIND_W-1:0]   i_kind,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [CNT_O_W-1:0]  o_window_frames,
    input wire logic [BITS_O_W-1:0] o_window_bits,
    input wire logic [MEAN_W-1:0]   o_mean_interval_ms
);

    localparam int CNT_MAX = (DEPTH > 127) ? 127 : DEPTH;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_kind == KIND_QUERY) |=> !o_in_ready)
        else $error("request taken during query walk");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_window_frames) <= CNT_MAX))
        else $error("frame count above ring depth");

    a_mean_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_window_frames < 7'd2) |-> (o_mean_interval_ms == '0))
        else $error("mean interval nonzero below two frames");

    a_bits_mult8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_window_bits[2:0] == 3'b000) || (o_window_bits == '1))
        else $error("window bits not a whole byte count");

endmodule

bind sliding_window_frame_rate_meter sfrm_checker #(
    .DEPTH (DEPTH)
) u_sfrm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_kind             (i_kind),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_window_frames    (o_window_frames),
    .o_window_bits      (o_window_bits),
    .o_mean_interval_ms (o_mean_interval_ms)
);

`default_nettype wire
